FILE: src/tagged_varint_value_encoder_assert.svh
// assertion macros for the tagged varint value encoder
// used by the port checker; no other dependencies
`ifndef TAGGED_VARINT_VALUE_ENCODER_ASSERT_SVH
`define TAGGED_VARINT_VALUE_ENCODER_ASSERT_SVH

// same-cycle implication
`define TVVE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TVVE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tvve_pkg.sv
// shared types and constants of the tagged varint value encoder
// no dependencies
package tvve_pkg;

   localparam logic [7:0] TAG_NULL    = 8'h00;
   localparam logic [7:0] TAG_FALSE   = 8'h01;
   localparam logic [7:0] TAG_TRUE    = 8'h02;
   localparam logic [7:0] TAG_INT     = 8'h03;
   localparam logic [7:0] TAG_UINT    = 8'h04;
   localparam logic [7:0] TAG_F32     = 8'h05;
   localparam logic [7:0] TAG_F64     = 8'h06;
   localparam logic [7:0] TAG_STR     = 8'h07;
   localparam logic [7:0] TAG_STRDICT = 8'h08;
   localparam logic [7:0] TAG_BYTES   = 8'h09;
   localparam logic [7:0] TAG_ARRAY   = 8'h0a;
   localparam logic [7:0] TAG_MAP     = 8'h0b;
   localparam logic [7:0] TAG_TYPETAG = 8'h0c;
   localparam logic [7:0] TAG_REFDEF  = 8'h0d;
   localparam logic [7:0] TAG_REFUSE  = 8'h0e;
   localparam logic [7:0] DICT_NEW    = 8'h00;
   localparam logic [7:0] ERR_MARKER  = 8'h00;

   localparam logic [7:0] DIGIT_MASK  = 8'h7f;
   localparam logic [7:0] CONT_BIT    = 8'h80;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SELF_DESCRIBING = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRING_DEDUP    = 2'd1;

   typedef enum logic [3:0] {
      OP_NULL    = 4'd0,
      OP_BOOL    = 4'd1,
      OP_INT     = 4'd2,
      OP_UINT    = 4'd3,
      OP_REAL32  = 4'd4,
      OP_REAL64  = 4'd5,
      OP_STR     = 4'd6,
      OP_BYTES   = 4'd7,
      OP_ARRAY   = 4'd8,
      OP_MAP     = 4'd9,
      OP_KEY     = 4'd10,
      OP_TYPETAG = 4'd11,
      OP_REFDEF  = 4'd12,
      OP_REFUSE  = 4'd13,
      OP_PAYLOAD = 4'd14
   } op_type;

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_VARINT,
      BODY_FIXED
   } body_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE0,
      ST_PRE1,
      ST_BODY
   } state_type;

   typedef struct packed {
      logic self_describing;
      logic string_dedup;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        fixed;
      logic        half;
      logic [63:0] value;
   } digit_ctl_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } digit_sts_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } out_item_type;

endpackage

FILE: src/tvve_if.sv
// channel interfaces of the tagged varint value encoder: request, response, csr
// depends on tvve_pkg
interface tvve_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         op;
   logic [63:0]        value;
   logic signed [31:0] count;
   logic               dict_hit;
   logic [31:0]        dict_id;

   modport source (output valid, op, value, count, dict_hit, dict_id, input ready);
   modport sink (input valid, op, value, count, dict_hit, dict_id, output ready);
endinterface

interface tvve_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       error;

   modport source (output valid, out_byte, last, error, input ready);
   modport sink (input valid, out_byte, last, error, output ready);
endinterface

interface tvve_csr_if import tvve_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic                  data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

FILE: src/tagged_varint_value_encoder.sv
// top level of the tagged varint value encoder: csr registers and unit wiring
// depends on tvve_pkg, tvve_if, tvve_digit, tvve_outbuf, tvve_seq
//
// req_chan takes one value token per item; rsp_chan gives the encoded bytes of
// that token, one byte per item, with last on the final byte. csr_chan writes
// self_describing (addr 0) and string_dedup (addr 1); it is always ready and
// writes other addresses to nothing. Change the registers only while idle.
// The sequencer is busy from the accept to the token's last byte: it sends the
// prefix bytes, then the body bytes of the digit shift register (7 bits each for
// a varint, 8 bits for a real), one byte per cycle while the output register has
// room; req_ready is high only while it is idle. The first byte passes the state
// register of the sequencer, then the output register, before rsp_chan offers it.
// A token that gives no bytes (unused op, or any op after an error) is taken and
// dropped while the sequencer stays idle. A negative container count gives a
// single byte with error and last set, then mutes all output until reset.
// A stalled receiver holds the byte in the output register and halts the
// sequencer. Reset (synchronous) clears the error flag and sets both registers.
module tagged_varint_value_encoder import tvve_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tvve_req_if.sink   req_chan,
   tvve_rsp_if.source rsp_chan,
   tvve_csr_if.sink   csr_chan
);

   cfg_type       cfg_ff, cfg_in;
   digit_ctl_type dctl;
   digit_sts_type dsts;
   out_item_type  item;
   logic          push, room;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_SELF_DESCRIBING: cfg_in.self_describing = csr_chan.data;
            CSR_STRING_DEDUP:    cfg_in.string_dedup    = csr_chan.data;
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{self_describing: 1'b1, string_dedup: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tvve_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .dctl     (dctl),
      .dsts     (dsts),
      .room     (room),
      .push     (push),
      .item     (item)
   );

   tvve_digit u_digit (
      .clock (clock),
      .dctl  (dctl),
      .dsts  (dsts)
   );

   tvve_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item     (item),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: src/tvve_digit.sv
// digit shift register: 7-bit varint groups or 8-bit fixed bytes, one per cycle while step is high
// depends on tvve_pkg
module tvve_digit import tvve_pkg::*; (
   input  logic          clock,
   input  digit_ctl_type dctl,
   output digit_sts_type dsts
);

   localparam logic [3:0] FIXED4_BYTES = 4'd4;
   localparam logic [3:0] FIXED8_BYTES = 4'd8;

   logic [63:0] sh_ff, sh_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        fixed_ff, fixed_in;
   logic        more;

   assign more = |sh_ff[63:7];

   always_comb begin
      sh_in    = sh_ff;
      cnt_in   = cnt_ff;
      fixed_in = fixed_ff;
      if (dctl.load) begin
         sh_in    = dctl.value;
         cnt_in   = dctl.half ? FIXED4_BYTES : FIXED8_BYTES;
         fixed_in = dctl.fixed;
      end else if (dctl.step) begin
         if (fixed_ff) begin
            sh_in  = {8'h00, sh_ff[63:8]};
            cnt_in = cnt_ff - 4'd1;
         end else begin
            sh_in = {7'h00, sh_ff[63:7]};
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff    <= sh_in;
      cnt_ff   <= cnt_in;
      fixed_ff <= fixed_in;
   end

   always_comb begin
      if (fixed_ff) begin
         dsts.out_byte = sh_ff[7:0];
         dsts.last     = (cnt_ff == 4'd1);
      end else begin
         dsts.out_byte = (more ? CONT_BIT : 8'h00) | (sh_ff[7:0] & DIGIT_MASK);
         dsts.last     = !more;
      end
   end

endmodule

FILE: src/tvve_outbuf.sv
// output register between the sequencer and the response channel
// depends on tvve_pkg and tvve_if
module tvve_outbuf import tvve_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  out_item_type item,
   output logic         room,
   tvve_rsp_if.source   rsp_chan
);

   logic         valid_ff, valid_in;
   out_item_type item_ff;

   assign room     = !valid_ff || rsp_chan.ready;
   assign valid_in = push || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= item;
      end
   end

   assign rsp_chan.valid    = valid_ff;
   assign rsp_chan.out_byte = item_ff.out_byte;
   assign rsp_chan.last     = item_ff.last;
   assign rsp_chan.error    = item_ff.error;

endmodule

FILE: src/tvve_seq.sv
// token decode and byte sequencer with the sticky error flag
// depends on tvve_pkg and tvve_if; drives tvve_digit and tvve_outbuf
module tvve_seq import tvve_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tvve_req_if.sink      req_chan,
   input  cfg_type       cfg,
   output digit_ctl_type dctl,
   input  digit_sts_type dsts,
   input  logic          room,
   output logic          push,
   output out_item_type  item
);

   state_type   state_ff, state_in;
   logic        sticky_ff, sticky_in;
   logic [7:0]  pre0_ff, pre1_ff;
   logic        has_p1_ff, err_ff;
   body_type    body_ff;

   logic [7:0]  dec_p0, dec_p1;
   logic        dec_has_p0, dec_has_p1, dec_fix4, dec_err, dec_drop, dec_dref;
   body_type    dec_body;
   logic [63:0] dec_val, zigzag;
   logic [32:0] id_inc;
   logic        accept, go;

   assign zigzag = {req_chan.value[62:0], 1'b0} ^ {64{req_chan.value[63]}};
   assign id_inc = {1'b0, req_chan.dict_id} + 33'd1;

   always_comb begin
      dec_p0     = TAG_NULL;
      dec_p1     = DICT_NEW;
      dec_has_p0 = 1'b0;
      dec_has_p1 = 1'b0;
      dec_body   = BODY_NONE;
      dec_fix4   = 1'b0;
      dec_val    = req_chan.value;
      dec_err    = 1'b0;
      dec_drop   = 1'b0;
      dec_dref   = 1'b0;
      unique case (op_type'(req_chan.op))
         OP_NULL: begin
            dec_has_p0 = 1'b1;
            dec_p0     = TAG_NULL;
         end
         OP_BOOL: begin
            dec_has_p0 = 1'b1;
            dec_p0     = (req_chan.value != 64'd0) ? TAG_TRUE : TAG_FALSE;
         end
         OP_INT: begin
            dec_body = BODY_VARINT;
            if (cfg.self_describing && !req_chan.value[63]) begin
               dec_has_p0 = 1'b1;
               dec_p0     = TAG_UINT;
            end else begin
               dec_has_p0 = cfg.self_describing;
               dec_p0     = TAG_INT;
               dec_val    = zigzag;
            end
         end
         OP_UINT: begin
            dec_has_p0 = cfg.self_describing;
            dec_p0     = TAG_UINT;
            dec_body   = BODY_VARINT;
         end
         OP_REAL32: begin
            dec_has_p0 = cfg.self_describing;
            dec_p0     = TAG_F32;
            dec_body   = BODY_FIXED;
            dec_fix4   = 1'b1;
            dec_val    = {32'd0, req_chan.value[31:0]};
         end
         OP_REAL64: begin
            dec_has_p0 = cfg.self_describing;
            dec_p0     = TAG_F64;
            dec_body   = BODY_FIXED;
         end
         OP_STR: begin
            dec_has_p0 = 1'b1;
            if (cfg.string_dedup) begin
               dec_p0   = TAG_STRDICT;
               dec_dref = 1'b1;
            end else begin
               dec_p0   = TAG_STR;
               dec_body = BODY_VARINT;
            end
         end
         OP_BYTES: begin
            dec_has_p0 = cfg.self_describing;
            dec_p0     = TAG_BYTES;
            dec_body   = BODY_VARINT;
         end
         OP_ARRAY, OP_MAP: begin
            dec_has_p0 = 1'b1;
            if (req_chan.count[31]) begin
               dec_p0  = ERR_MARKER;
               dec_err = 1'b1;
            end else begin
               dec_p0   = (op_type'(req_chan.op) == OP_ARRAY) ? TAG_ARRAY : TAG_MAP;
               dec_body = BODY_VARINT;
               dec_val  = {32'd0, $unsigned(req_chan.count)};
            end
         end
         OP_KEY: begin
            dec_dref = 1'b1;
         end
         OP_TYPETAG: begin
            dec_has_p0 = 1'b1;
            dec_p0     = TAG_TYPETAG;
            dec_dref   = 1'b1;
         end
         OP_REFDEF: begin
            dec_has_p0 = 1'b1;
            dec_p0     = TAG_REFDEF;
            dec_body   = BODY_VARINT;
         end
         OP_REFUSE: begin
            dec_has_p0 = 1'b1;
            dec_p0     = TAG_REFUSE;
            dec_body   = BODY_VARINT;
         end
         OP_PAYLOAD: begin
            dec_has_p0 = 1'b1;
            dec_p0     = req_chan.value[7:0];
         end
         default: begin
            dec_drop = 1'b1;
         end
      endcase
      // dictionary reference: id+1, or a zero byte then the length
      if (dec_dref) begin
         dec_body = BODY_VARINT;
         if (req_chan.dict_hit) begin
            dec_val = {31'd0, id_inc};
         end else if (dec_has_p0) begin
            dec_has_p1 = 1'b1;
            dec_p1     = DICT_NEW;
         end else begin
            dec_has_p0 = 1'b1;
            dec_p0     = DICT_NEW;
         end
      end
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign go        = accept && !sticky_ff && !dec_drop;
   assign sticky_in = sticky_ff || (go && dec_err);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = dec_has_p0 ? ST_PRE0 : ST_BODY;
            end
         end
         ST_PRE0: begin
            if (room) begin
               if (has_p1_ff) begin
                  state_in = ST_PRE1;
               end else if (body_ff == BODY_NONE) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_PRE1: begin
            if (room) begin
               state_in = (body_ff == BODY_NONE) ? ST_IDLE : ST_BODY;
            end
         end
         ST_BODY: begin
            if (room && dsts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      push           = 1'b0;
      item           = '0;
      dctl.load      = go;
      dctl.step      = 1'b0;
      dctl.fixed     = (dec_body == BODY_FIXED);
      dctl.half      = dec_fix4;
      dctl.value     = dec_val;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_PRE0: begin
            push          = room;
            item.out_byte = pre0_ff;
            item.last     = !has_p1_ff && (body_ff == BODY_NONE);
            item.error    = err_ff;
         end
         ST_PRE1: begin
            push          = room;
            item.out_byte = pre1_ff;
            item.last     = (body_ff == BODY_NONE);
         end
         ST_BODY: begin
            push          = room;
            item.out_byte = dsts.out_byte;
            item.last     = dsts.last;
            dctl.step     = room;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sticky_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         pre0_ff   <= dec_p0;
         pre1_ff   <= dec_p1;
         has_p1_ff <= dec_has_p1;
         body_ff   <= dec_body;
         err_ff    <= dec_err;
      end
   end

endmodule

FILE: src/tvve_checker.sv
// port checker for the tagged varint value encoder, bound to the top level
// depends on tagged_varint_value_encoder_assert.svh
`include "tagged_varint_value_encoder_assert.svh"

module tvve_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_error
);

   `TVVE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_error), "stalled response item changed")
   `TVVE_ASSERT_IMPLY(a_err_last, clock, reset, rsp_valid && rsp_error, rsp_last, "error item not marked last")
   `TVVE_ASSERT_NEXT(a_err_mute, clock, reset, rsp_valid && rsp_ready && rsp_error, !rsp_valid, "output after error item")
   `TVVE_ASSERT_IMPLY(a_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "request taken mid token")

endmodule

bind tagged_varint_value_encoder tvve_checker u_tvve_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_last     (rsp_chan.last),
   .rsp_error    (rsp_chan.error)
);
